// ----- hw/rtl/pebc_pkg.sv -----
// ----------------------------------------------------------------------------
// pebc_pkg
// Shared widths, register codes, datapath selects and the control program
// of the position error biquad compensator.
// ----------------------------------------------------------------------------
package pebc_pkg;

  localparam int CountW   = 32;
  localparam int ScaleW   = 24;
  localparam int CoefW    = 18;
  localparam int DutyW    = 16;
  localparam int QW       = 32;
  localparam int SumW     = CountW + 2;
  localparam int OpAW     = ScaleW + 1;
  localparam int OpBW     = QW;
  localparam int ProdW    = OpAW + OpBW;
  localparam int AccW     = ProdW + 1;
  localparam int HiProdW  = (SumW - 16) + ScaleW;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = ScaleW;
  localparam int ProgLen  = 9;
  localparam int StepW    = $clog2(ProgLen);
  localparam int DutyMax  = 32767;

  typedef enum logic [CfgIdxW-1:0] {
    REG_COUNT_SCALE = 3'd0,
    REG_COEF_B0     = 3'd1,
    REG_COEF_B1     = 3'd2,
    REG_COEF_B2     = 3'd3,
    REG_COEF_A1     = 3'd4,
    REG_COEF_A2     = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    A_SCALE,
    A_B0,
    A_B1,
    A_B2,
    A_A1,
    A_A2
  } a_sel_t;

  typedef enum logic [2:0] {
    B_SUM_LO,
    B_SUM_HI,
    B_ERR,
    B_E1,
    B_E2,
    B_Y1,
    B_Y2
  } b_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_ADD_HI
  } acc_op_t;

  typedef struct packed {
    a_sel_t  a_sel;
    b_sel_t  b_sel;
    acc_op_t acc_op;
    logic    commit_err;
    logic    skip_on_stop;
    logic    finish;
  } ctrl_t;

  localparam logic [StepW-1:0] FinishStep = StepW'(ProgLen - 1);

  // control program, one word per step
  function automatic ctrl_t prog_word(input logic [StepW-1:0] step);
    ctrl_t w;
    w = '{a_sel: A_SCALE, b_sel: B_SUM_LO, acc_op: ACC_HOLD,
          commit_err: 1'b0, skip_on_stop: 1'b0, finish: 1'b0};
    unique case (step)
      4'd0: begin
        w.a_sel = A_SCALE;
        w.b_sel = B_SUM_LO;
      end
      4'd1: begin
        w.a_sel  = A_SCALE;
        w.b_sel  = B_SUM_HI;
        w.acc_op = ACC_LOAD;
      end
      4'd2: begin
        w.a_sel  = A_A1;
        w.b_sel  = B_Y1;
        w.acc_op = ACC_ADD_HI;
      end
      4'd3: begin
        w.a_sel        = A_A2;
        w.b_sel        = B_Y2;
        w.acc_op       = ACC_LOAD;
        w.commit_err   = 1'b1;
        w.skip_on_stop = 1'b1;
      end
      4'd4: begin
        w.a_sel  = A_B1;
        w.b_sel  = B_E1;
        w.acc_op = ACC_ADD;
      end
      4'd5: begin
        w.a_sel  = A_B2;
        w.b_sel  = B_E2;
        w.acc_op = ACC_ADD;
      end
      4'd6: begin
        w.a_sel  = A_B0;
        w.b_sel  = B_ERR;
        w.acc_op = ACC_ADD;
      end
      4'd7: begin
        w.acc_op = ACC_ADD;
      end
      4'd8: begin
        w.finish = 1'b1;
      end
      default: begin
        w.finish = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

// ----- hw/rtl/position_error_biquad_compensator.sv -----
// ----------------------------------------------------------------------------
// position_error_biquad_compensator
// Scales the leader/follower encoder position error to Q16.16 and runs a
// direct form I biquad over it, emitting a clamped Q1.15 motor duty.
// ----------------------------------------------------------------------------
//  channel   handshake               payload
//  input     in_valid / in_stall     leader_count, follower_count, stopping
//  output    out_valid / out_stall   duty
//  config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
//  one item at a time: an item runs nine program steps, and no new item is
//  taken until it is done; the single shared 25x32 multiplier takes one
//  product per step. a stopping item jumps from step 3 to the final step.
//  rst clears the coefficients to defaults and all histories to zero.
//  the final step waits while a previous duty is still stalled at the output.
// ----------------------------------------------------------------------------
module position_error_biquad_compensator
  import pebc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [CountW-1:0]   leader_count,
  input  logic signed [CountW-1:0]   follower_count,
  input  logic                       stopping,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [DutyW-1:0]    duty,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CfgIdxW-1:0]         cfg_index,
  input  logic [CfgDataW-1:0]        cfg_data
);

  logic [ScaleW-1:0]       count_scale;
  logic signed [CoefW-1:0] coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;

  logic signed [QW-1:0]    last_error, older_error, last_output, older_output;
  logic signed [QW-1:0]    err;
  logic signed [SumW-1:0]  sum;
  logic                    stop;

  logic                    busy;
  logic [StepW-1:0]        step, step_next;
  ctrl_t                   ctrl;

  logic signed [OpAW-1:0]  op_a;
  logic signed [OpBW-1:0]  op_b;
  logic signed [ProdW-1:0] prod;
  logic signed [AccW-1:0]  acc, acc_next;
  logic signed [AccW-1:0]  err_rnd, y_rnd;
  logic signed [QW-1:0]    err_sat, y_sat;
  logic signed [QW:0]      d_full;
  logic signed [DutyW-1:0] d_clamp;
  logic                    in_accept, out_free, finishing;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy;
  assign in_accept = in_valid && !busy;
  assign ctrl      = prog_word(step);
  assign out_free  = !out_valid || !out_stall;
  assign finishing = busy && ctrl.finish && out_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count_scale <= ScaleW'(49637);
      coef_b0     <= CoefW'(46819);
      coef_b1     <= -CoefW'(25998);
      coef_b2     <= -CoefW'(19779);
      coef_a1     <= CoefW'(25867);
      coef_a2     <= CoefW'(38365);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_COUNT_SCALE: count_scale <= cfg_data;
        REG_COEF_B0:     coef_b0     <= cfg_data[CoefW-1:0];
        REG_COEF_B1:     coef_b1     <= cfg_data[CoefW-1:0];
        REG_COEF_B2:     coef_b2     <= cfg_data[CoefW-1:0];
        REG_COEF_A1:     coef_a1     <= cfg_data[CoefW-1:0];
        REG_COEF_A2:     coef_a2     <= cfg_data[CoefW-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    if (ctrl.skip_on_stop && stop) begin
      step_next = FinishStep;
    end else begin
      step_next = step + StepW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (in_accept) begin
      busy <= 1'b1;
      step <= '0;
    end else if (finishing) begin
      busy <= 1'b0;
      step <= '0;
    end else if (busy && !ctrl.finish) begin
      step <= step_next;
    end
  end

  // operand selection
  always_comb begin
    unique case (ctrl.a_sel)
      A_SCALE: op_a = signed'({1'b0, count_scale});
      A_B0:    op_a = OpAW'(coef_b0);
      A_B1:    op_a = OpAW'(coef_b1);
      A_B2:    op_a = OpAW'(coef_b2);
      A_A1:    op_a = OpAW'(coef_a1);
      A_A2:    op_a = OpAW'(coef_a2);
      default: op_a = '0;
    endcase
    unique case (ctrl.b_sel)
      B_SUM_LO: op_b = signed'({16'b0, sum[15:0]});
      B_SUM_HI: op_b = OpBW'(signed'(sum[SumW-1:16]));
      B_ERR:    op_b = err;
      B_E1:     op_b = last_error;
      B_E2:     op_b = older_error;
      B_Y1:     op_b = last_output;
      B_Y2:     op_b = older_output;
      default:  op_b = '0;
    endcase
  end

  // accumulator
  always_comb begin
    case (ctrl.acc_op)
      ACC_LOAD:   acc_next = AccW'(prod);
      ACC_ADD:    acc_next = acc + AccW'(prod);
      ACC_ADD_HI: acc_next = acc + signed'({prod[HiProdW-1:0], 16'b0});
      default:    acc_next = acc;
    endcase
  end

  // rounding and saturation
  always_comb begin
    err_rnd = (acc + AccW'(128)) >>> 8;
    if (!(&err_rnd[AccW-1:QW-1] || ~|err_rnd[AccW-1:QW-1])) begin
      err_sat = err_rnd[AccW-1] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
    end else begin
      err_sat = err_rnd[QW-1:0];
    end
    y_rnd = (acc + AccW'(32768)) >>> 16;
    if (!(&y_rnd[AccW-1:QW-1] || ~|y_rnd[AccW-1:QW-1])) begin
      y_sat = y_rnd[AccW-1] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
    end else begin
      y_sat = y_rnd[QW-1:0];
    end
    d_full = (signed'({y_sat[QW-1], y_sat}) + (QW+1)'(1)) >>> 1;
    if (d_full > (QW+1)'(DutyMax)) begin
      d_clamp = DutyW'(DutyMax);
    end else if (d_full < -(QW+1)'(DutyMax)) begin
      d_clamp = -DutyW'(DutyMax);
    end else begin
      d_clamp = d_full[DutyW-1:0];
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_accept) begin
      sum  <= -SumW'(leader_count) - SumW'(follower_count);
      stop <= stopping;
    end
    if (busy) begin
      prod <= op_a * op_b;
      acc  <= acc_next;
      if (ctrl.commit_err) begin
        err <= err_sat;
      end
    end
  end

  // history
  always_ff @(posedge clk) begin
    if (rst) begin
      last_error   <= '0;
      older_error  <= '0;
      last_output  <= '0;
      older_output <= '0;
    end else if (finishing) begin
      older_error  <= last_error;
      last_error   <= err;
      older_output <= last_output;
      if (!stop) begin
        last_output <= y_sat;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finishing) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finishing) begin
      duty <= stop ? '0 : d_clamp;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    busy |-> step < StepW'(ProgLen))
    else $error("step counter ran past the program");

  assert property (@(posedge clk) disable iff (rst)
    !busy |-> step == '0)
    else $error("step counter not parked while idle");

  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> busy && step == '0)
    else $error("accepted transaction did not start the program");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !$past(out_valid) |-> $past(busy))
    else $error("output raised without a running program");

  assert property (@(posedge clk) disable iff (rst)
    busy && ctrl.skip_on_stop && stop |=> step == FinishStep)
    else $error("stopping transaction did not jump to the final step");

endmodule
